FILE: rtl/core/dcc_pkg.sv
// Package for the DAG cycle checker: sizes, sequencer states, link codes.
// No dependencies.
package dcc_pkg;

    localparam int MaxVertices = 2048;
    localparam int MaxEdges    = 4096;
    localparam int VW          = $clog2(MaxVertices);     // vertex index width
    localparam int EW          = $clog2(MaxEdges);        // edge index width
    localparam int LW          = EW + 1;                  // link width, MaxEdges = none
    localparam int CW          = VW + 1;                  // vertex count width
    localparam int DW          = EW + 1;                  // in-degree width

    localparam logic [LW-1:0] LinkNone = LW'(MaxEdges);

    localparam logic ReqAdd  = 1'b0;
    localparam logic ReqEval = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_RD,      // read chain head of source
        ST_ADD_WR,      // write edge and new head
        ST_CLR,         // clear in-degree
        ST_DEG_HEAD,    // issue head read for vertex v
        ST_DEG_HWAIT,
        ST_DEG_EDGE,    // edge record read issued
        ST_DEG_EWAIT,
        ST_DEG_INC,     // in-degree read issued
        ST_DEG_IWAIT,
        ST_SCAN,        // issue in-degree read of v
        ST_SCAN_WAIT,
        ST_POP,         // issue queue read
        ST_POP_WAIT,
        ST_POP_HEAD,
        ST_POP_HWAIT,
        ST_POP_EDGE,
        ST_POP_EWAIT,
        ST_POP_DEC,
        ST_POP_DWAIT,
        ST_EMIT,
        ST_WIPE         // reset chain heads
    } state_t;

endpackage

FILE: rtl/core/dcc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dcc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/core/dag_cycle_check.sv
// DAG cycle checker top level: edge store and Kahn sequencer.
// Depends on dcc_pkg and dcc_ram.
// Add request: busy while the head read and edge write run; no new add is taken
// until then, and a dropped add leaves busy low. Evaluate: clear, head visits and
// stored edge visits (two passes), scan, pops, emit, then a full head wipe.
// Reset: async active low; after reset all chain heads are wiped with busy high.
// Results last one cycle on done; the receiver cannot stall.
module dag_cycle_check (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [dcc_pkg::VW-1:0] edge_source,
    input  logic [dcc_pkg::VW-1:0] edge_target,
    input  logic                  cfg_we,
    input  logic [11:0]           cfg_data,
    output logic                  done,
    output logic                  cycle_found,
    output logic [11:0]           ordered_count,
    output logic [1:0]            status
);
    import dcc_pkg::*;

    state_t state_reg, state_next;
    logic [11:0]   vcount_reg;
    logic [EW:0]   total_reg, total_next;
    logic [1:0]    err_reg, err_next;
    logic [CW-1:0] v_reg, v_next;          // vertex sweep counter
    logic [LW-1:0] e_reg, e_next;          // chain walk pointer
    logic [VW-1:0] d_reg, d_next;          // current destination
    logic [VW-1:0] src_reg, src_next;
    logic [VW-1:0] dst_reg, dst_next;
    logic [CW-1:0] front_reg, front_next, rear_reg, rear_next;
    logic [CW-1:0] n_live;

    // RAM ports
    logic          h_we, q_we, g_we, ed_we;
    logic [VW-1:0] h_addr, q_addr, g_addr;
    logic [EW-1:0] ed_addr;
    logic [LW-1:0] h_wd, h_rd;
    logic [VW-1:0] q_wd, q_rd;
    logic [DW-1:0] g_wd, g_rd;
    logic [LW+VW-1:0] ed_wd, ed_rd;

    dcc_ram #(.Width(LW), .Depth(MaxVertices)) u_head
        (.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
    dcc_ram #(.Width(LW + VW), .Depth(MaxEdges)) u_edge
        (.clk(clk), .we(ed_we), .addr(ed_addr), .wdata(ed_wd), .rdata(ed_rd));
    dcc_ram #(.Width(DW), .Depth(MaxVertices)) u_deg
        (.clk(clk), .we(g_we), .addr(g_addr), .wdata(g_wd), .rdata(g_rd));
    dcc_ram #(.Width(VW), .Depth(MaxVertices)) u_queue
        (.clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd));

    // saturate count to store size
    assign n_live = (vcount_reg > 12'(MaxVertices)) ? CW'(MaxVertices) : CW'(vcount_reg);

    logic [LW-1:0] nx_link;
    logic [VW-1:0] nx_dest;
    assign nx_link = ed_rd[LW+VW-1:VW];
    assign nx_dest = ed_rd[VW-1:0];

    logic link_ok;
    assign link_ok = ({1'b0, e_reg} < {1'b0, total_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_WIPE;
            vcount_reg <= 12'd1;
            total_reg  <= '0;
            err_reg    <= '0;
            v_reg      <= '0;
            e_reg      <= '0;
            d_reg      <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            front_reg  <= '0;
            rear_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
            total_reg <= total_next;
            err_reg   <= err_next;
            v_reg     <= v_next;
            e_reg     <= e_next;
            d_reg     <= d_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        err_next   = err_reg;
        v_next     = v_reg;
        e_next     = e_reg;
        d_next     = d_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        front_next = front_reg;
        rear_next  = rear_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    src_next = edge_source;
                    dst_next = edge_target;
                    v_next   = '0;
                    if (req_type == ReqEval)
                    begin
                        state_next = (n_live == '0) ? ST_EMIT : ST_CLR;
                    end
                    else if ({1'b0, edge_source} >= n_live || {1'b0, edge_target} >= n_live)
                    begin
                        err_next[0] = 1'b1;
                    end
                    else if (total_reg == (EW+1)'(MaxEdges))
                    begin
                        err_next[1] = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_ADD_RD;
                    end
                end
            end
            ST_ADD_RD:    state_next = ST_ADD_WR;
            ST_ADD_WR:
            begin
                total_next = total_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLR:
            begin
                v_next = v_reg + 1'b1;
                if (v_reg + 1'b1 == n_live)
                begin
                    v_next     = '0;
                    state_next = ST_DEG_HEAD;
                end
            end
            ST_DEG_HEAD:  state_next = ST_DEG_HWAIT;
            ST_DEG_HWAIT:
            begin
                e_next     = h_rd;
                state_next = ST_DEG_EDGE;
            end
            ST_DEG_EDGE:
            begin
                if (link_ok)
                begin
                    state_next = ST_DEG_EWAIT;
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                    if (v_reg + 1'b1 == n_live)
                    begin
                        v_next     = '0;
                        rear_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DEG_HEAD;
                    end
                end
            end
            ST_DEG_EWAIT:
            begin
                e_next = nx_link;
                d_next = nx_dest;
                state_next = ({1'b0, nx_dest} < n_live) ? ST_DEG_INC : ST_DEG_EDGE;
            end
            ST_DEG_INC:   state_next = ST_DEG_IWAIT;
            ST_DEG_IWAIT: state_next = ST_DEG_EDGE;
            ST_SCAN:      state_next = ST_SCAN_WAIT;
            ST_SCAN_WAIT:
            begin
                if (g_rd == '0)
                begin
                    rear_next = rear_reg + 1'b1;
                end
                v_next = v_reg + 1'b1;
                if (v_reg + 1'b1 == n_live)
                begin
                    front_next = '0;
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_POP:
            begin
                state_next = (front_reg < rear_reg) ? ST_POP_WAIT : ST_EMIT;
            end
            ST_POP_WAIT:
            begin
                front_next = front_reg + 1'b1;
                state_next = ST_POP_HEAD;
            end
            ST_POP_HEAD:  state_next = ST_POP_HWAIT;
            ST_POP_HWAIT:
            begin
                e_next     = h_rd;
                state_next = ST_POP_EDGE;
            end
            ST_POP_EDGE:
            begin
                state_next = link_ok ? ST_POP_EWAIT : ST_POP;
            end
            ST_POP_EWAIT:
            begin
                e_next = nx_link;
                d_next = nx_dest;
                state_next = ({1'b0, nx_dest} < n_live) ? ST_POP_DEC : ST_POP_EDGE;
            end
            ST_POP_DEC:   state_next = ST_POP_DWAIT;
            ST_POP_DWAIT:
            begin
                if (g_rd == DW'(1) && rear_reg < CW'(MaxVertices))
                begin
                    rear_next = rear_reg + 1'b1;
                end
                state_next = ST_POP_EDGE;
            end
            ST_EMIT:
            begin
                v_next     = '0;
                total_next = '0;
                err_next   = '0;
                state_next = ST_WIPE;
            end
            ST_WIPE:
            begin
                v_next = v_reg + 1'b1;
                if (v_reg == CW'(MaxVertices - 1))
                begin
                    v_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // RAM control and outputs
    always_comb
    begin
        h_we = 1'b0; h_addr = v_reg[VW-1:0]; h_wd = LinkNone;
        ed_we = 1'b0; ed_addr = e_reg[EW-1:0]; ed_wd = {h_rd, dst_reg};
        g_we = 1'b0; g_addr = v_reg[VW-1:0]; g_wd = '0;
        q_we = 1'b0; q_addr = rear_reg[VW-1:0]; q_wd = v_reg[VW-1:0];
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:      h_addr = edge_source;
            ST_ADD_RD:    h_addr = src_reg;
            ST_ADD_WR:
            begin
                h_addr  = src_reg;
                h_we    = 1'b1;
                h_wd    = LW'(total_reg);
                ed_we   = 1'b1;
                ed_addr = total_reg[EW-1:0];
            end
            ST_CLR:       g_we = 1'b1;
            ST_DEG_INC, ST_DEG_IWAIT:
            begin
                g_addr = d_reg;
                g_we   = (state_reg == ST_DEG_IWAIT);
                g_wd   = g_rd + 1'b1;
            end
            ST_SCAN_WAIT: q_we = (g_rd == '0);
            ST_POP, ST_POP_WAIT: q_addr = front_reg[VW-1:0];
            ST_POP_HEAD:  h_addr = q_rd;
            ST_POP_DEC, ST_POP_DWAIT:
            begin
                g_addr = d_reg;
                g_we   = (state_reg == ST_POP_DWAIT) && (g_rd != '0);
                g_wd   = g_rd - 1'b1;
                q_wd   = d_reg;
                q_we   = (state_reg == ST_POP_DWAIT) && (g_rd == DW'(1))
                         && (rear_reg < CW'(MaxVertices));
            end
            ST_EMIT:      done = 1'b1;
            ST_WIPE:      h_we = 1'b1;
            default:      ;
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cycle_found   = (front_reg != n_live) && (n_live != '0);
    assign ordered_count = (n_live == '0) ? 12'd0 : 12'(front_reg);
    assign status        = err_reg;
endmodule
